// ===== design/memory_test_pattern_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Memory test pattern checker - assertion macros
// Shared concurrent assertion forms, clocked and disabled by the module reset.
// ----------------------------------------------------------------------------
`ifndef MEMORY_TEST_PATTERN_CHECKER_ASSERT_SVH
`define MEMORY_TEST_PATTERN_CHECKER_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define MTPC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: lbl failed");

// Antecedent implies consequent in the next cycle
`define MTPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: lbl failed");

`endif

// ===== design/mtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Memory test pattern checker package
// Sizes, register codes and the request queue entry shared by all modules.
// ----------------------------------------------------------------------------
package mtpc_pkg;

   localparam int WORDS_PER_LINE = 8;
   localparam int LINES_PER_ROW  = 128;
   localparam int MAX_ROWS       = 32768;
   localparam int MAX_BANKS      = 16;

   localparam int WORD_W    = $clog2(WORDS_PER_LINE);
   localparam int LINE_W    = $clog2(LINES_PER_ROW);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int BANK_W    = $clog2(MAX_BANKS);
   localparam int ROWS_W    = 16;
   localparam int BANKS_W   = 5;
   localparam int PATTERN_W = 32;
   localparam int DATA_W    = 64;
   localparam int BYTES     = DATA_W / 8;
   localparam int TOTAL_W   = 33;
   localparam int CNT_W     = $clog2(BYTES + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ROWS_W-1:0]    ROWS_RESET  = ROWS_W'(MAX_ROWS);
   localparam logic [BANKS_W-1:0]   BANKS_RESET = BANKS_W'(MAX_BANKS);
   localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SEED_PATTERN  = 2'd0,
      REG_ROWS_PER_BANK = 2'd1,
      REG_BANK_COUNT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0]    read_word;
      logic [PATTERN_W-1:0] pattern;
      logic [BANK_W-1:0]    bank;
      logic [ROW_W-1:0]     row;
      logic [LINE_W-1:0]    line;
      logic [WORD_W-1:0]    word;
      logic                 active;
      logic                 done;
   } q_entry_type;

endpackage

// ===== design/mtpc_if.sv =====
// ----------------------------------------------------------------------------
// Memory test pattern checker channels
// Valid/ready channels for read words, check results and register writes.
// ----------------------------------------------------------------------------
interface mtpc_req_if;
   logic                          valid;
   logic                          ready;
   logic [mtpc_pkg::DATA_W-1:0]   read_word;

   modport source (output valid, output read_word, input ready);
   modport sink   (input valid, input read_word, output ready);
endinterface

interface mtpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mtpc_pkg::BYTES-1:0]     mismatch_mask;
   logic [mtpc_pkg::PATTERN_W-1:0] expected_pattern;
   logic [mtpc_pkg::BANK_W-1:0]    bank_index;
   logic [mtpc_pkg::ROW_W-1:0]     row_index;
   logic [mtpc_pkg::LINE_W-1:0]    line_index;
   logic [mtpc_pkg::WORD_W-1:0]    word_index;
   logic [mtpc_pkg::TOTAL_W-1:0]   error_total;
   logic                           run_done;

   modport source (output valid, output mismatch_mask, output expected_pattern,
                   output bank_index, output row_index, output line_index,
                   output word_index, output error_total, output run_done,
                   input ready);
   modport sink   (input valid, input mismatch_mask, input expected_pattern,
                   input bank_index, input row_index, input line_index,
                   input word_index, input error_total, input run_done,
                   output ready);
endinterface

interface mtpc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mtpc_pkg::CSR_INDEX_W-1:0]  index;
   logic [mtpc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/memory_test_pattern_checker.sv =====
// ----------------------------------------------------------------------------
// Memory test pattern checker
// Usage:
//   req_port carries one 64-bit read word per request; eight words form a line,
//   128 lines a row. rsp_port returns one result per request, in order: byte
//   mismatch mask, expected pattern, bank/row/line/word position, running
//   mismatch byte total (saturating) and the done flag.
//   csr_port writes seed_pattern (0), rows_per_bank (1) and bank_count (2);
//   write only while no request is in flight. A seed write also loads the
//   working pattern until the first word is checked after reset.
//   A taken request is written into the queue; its result is registered as
//   it leaves the queue head. Throughput: one request per cycle while the
//   queue has room, set by the front position/pattern update and back compare.
//   Reset clears positions, totals and queue and restores register defaults.
//   When rsp_port stalls, the result register holds, the two-entry queue
//   fills and req_port.ready drops once it is full.
//   After the last row of the last bank, requests return a zero mask and
//   run_done high.
// ----------------------------------------------------------------------------
module memory_test_pattern_checker (
   input  logic         clock,
   input  logic         reset,
   mtpc_req_if.sink     req_port,
   mtpc_rsp_if.source   rsp_port,
   mtpc_csr_if.sink     csr_port
);

   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   mtpc_pkg::q_entry_type  push_entry;
   mtpc_pkg::q_entry_type  head_entry;

   mtpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .csr_port (csr_port),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   mtpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   mtpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (head_entry),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

endmodule

// ===== design/mtpc_front.sv =====
// ----------------------------------------------------------------------------
// Memory test pattern checker front end
// Holds configuration, tracks pattern and word position, tags each request.
// ----------------------------------------------------------------------------
`include "memory_test_pattern_checker_assert.svh"

module mtpc_front (
   input  logic                   clock,
   input  logic                   reset,
   mtpc_req_if.sink               req_port,
   mtpc_csr_if.sink               csr_port,
   input  logic                   q_full,
   output logic                   q_push,
   output mtpc_pkg::q_entry_type  q_entry
);

   logic [mtpc_pkg::PATTERN_W-1:0] seed_ff, seed_in;
   logic [mtpc_pkg::ROWS_W-1:0]    rows_ff, rows_in;
   logic [mtpc_pkg::BANKS_W-1:0]   banks_ff, banks_in;
   logic [mtpc_pkg::PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [mtpc_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [mtpc_pkg::LINE_W-1:0]    line_ff, line_in;
   logic [mtpc_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [mtpc_pkg::BANK_W-1:0]    bank_ff, bank_in;
   logic                           finished_ff, finished_in;
   logic                           started_ff, started_in;

   logic                           accept;
   logic                           active;
   logic [mtpc_pkg::ROWS_W-1:0]    rows_lim;
   logic [mtpc_pkg::BANKS_W-1:0]   banks_lim;
   logic                           word_last, line_last, row_last, bank_last;
   logic [mtpc_pkg::PATTERN_W-1:0] pat_rot, pat_mul;

   assign req_port.ready = !q_full;
   assign csr_port.ready = 1'b1;
   assign accept         = req_port.valid && !q_full;
   assign active         = !finished_ff;

   always_comb begin
      if (rows_ff == '0) begin
         rows_lim = mtpc_pkg::ROWS_W'(1);
      end else if (rows_ff > mtpc_pkg::ROWS_W'(mtpc_pkg::MAX_ROWS)) begin
         rows_lim = mtpc_pkg::ROWS_W'(mtpc_pkg::MAX_ROWS);
      end else begin
         rows_lim = rows_ff;
      end
      if (banks_ff == '0) begin
         banks_lim = mtpc_pkg::BANKS_W'(1);
      end else if (banks_ff > mtpc_pkg::BANKS_W'(mtpc_pkg::MAX_BANKS)) begin
         banks_lim = mtpc_pkg::BANKS_W'(mtpc_pkg::MAX_BANKS);
      end else begin
         banks_lim = banks_ff;
      end
   end

   assign word_last = word_ff == mtpc_pkg::WORD_W'(mtpc_pkg::WORDS_PER_LINE - 1);
   assign line_last = line_ff == mtpc_pkg::LINE_W'(mtpc_pkg::LINES_PER_ROW - 1);
   assign row_last  = ({1'b0, row_ff} + (mtpc_pkg::ROW_W + 1)'(1)) >=
                      (mtpc_pkg::ROW_W + 1)'(rows_lim);
   assign bank_last = (mtpc_pkg::BANKS_W'(bank_ff) + mtpc_pkg::BANKS_W'(1)) >= banks_lim;
   assign pat_rot   = {pattern_ff[0], pattern_ff[mtpc_pkg::PATTERN_W-1:1]};
   assign pat_mul   = pat_rot + {pat_rot[mtpc_pkg::PATTERN_W-2:0], 1'b0};

   always_comb begin
      seed_in     = seed_ff;
      rows_in     = rows_ff;
      banks_in    = banks_ff;
      pattern_in  = pattern_ff;
      word_in     = word_ff;
      line_in     = line_ff;
      row_in      = row_ff;
      bank_in     = bank_ff;
      finished_in = finished_ff;
      started_in  = started_ff;
      if (csr_port.valid) begin
         case (mtpc_pkg::csr_index_type'(csr_port.index))
            mtpc_pkg::REG_SEED_PATTERN: begin
               seed_in = csr_port.data;
               if (!started_ff) begin
                  pattern_in = csr_port.data;
               end
            end
            mtpc_pkg::REG_ROWS_PER_BANK: begin
               rows_in = csr_port.data[mtpc_pkg::ROWS_W-1:0];
            end
            mtpc_pkg::REG_BANK_COUNT: begin
               banks_in = csr_port.data[mtpc_pkg::BANKS_W-1:0];
            end
            default: begin
            end
         endcase
      end
      if (accept && active) begin
         started_in = 1'b1;
         word_in    = word_ff + mtpc_pkg::WORD_W'(1);
         if (word_last) begin
            word_in    = '0;
            pattern_in = pat_rot;
            line_in    = line_ff + mtpc_pkg::LINE_W'(1);
            if (line_last) begin
               line_in    = '0;
               pattern_in = pat_mul;
               row_in     = row_ff + mtpc_pkg::ROW_W'(1);
               if (row_last) begin
                  row_in  = '0;
                  bank_in = bank_ff + mtpc_pkg::BANK_W'(1);
                  if (bank_last) begin
                     bank_in     = '0;
                     finished_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         rows_ff     <= mtpc_pkg::ROWS_RESET;
         banks_ff    <= mtpc_pkg::BANKS_RESET;
         pattern_ff  <= '0;
         word_ff     <= '0;
         line_ff     <= '0;
         row_ff      <= '0;
         bank_ff     <= '0;
         finished_ff <= 1'b0;
         started_ff  <= 1'b0;
      end else begin
         seed_ff     <= seed_in;
         rows_ff     <= rows_in;
         banks_ff    <= banks_in;
         pattern_ff  <= pattern_in;
         word_ff     <= word_in;
         line_ff     <= line_in;
         row_ff      <= row_in;
         bank_ff     <= bank_in;
         finished_ff <= finished_in;
         started_ff  <= started_in;
      end
   end

   assign q_push            = accept;
   assign q_entry.read_word = req_port.read_word;
   assign q_entry.pattern   = pattern_ff;
   assign q_entry.bank      = bank_ff;
   assign q_entry.row       = row_ff;
   assign q_entry.line      = line_ff;
   assign q_entry.word      = word_ff;
   assign q_entry.active    = active;
   assign q_entry.done      = finished_in;

   `MTPC_ASSERT_ALWAYS(a_done_positions_zero, clock, reset,
      !finished_ff || (word_ff == '0 && line_ff == '0 && row_ff == '0 && bank_ff == '0))

endmodule

// ===== design/mtpc_queue.sv =====
// ----------------------------------------------------------------------------
// Memory test pattern checker request queue
// Short FIFO of tagged requests between front end and compare back end.
// ----------------------------------------------------------------------------
`include "memory_test_pattern_checker_assert.svh"

module mtpc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mtpc_pkg::q_entry_type  push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output mtpc_pkg::q_entry_type  head_entry
);

   mtpc_pkg::q_entry_type          entry_ff [mtpc_pkg::QUEUE_DEPTH];
   logic [mtpc_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mtpc_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mtpc_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           do_push, do_pop;

   assign full       = count_ff == mtpc_pkg::QCNT_W'(mtpc_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mtpc_pkg::QPTR_W'(mtpc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mtpc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mtpc_pkg::QPTR_W'(mtpc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mtpc_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + mtpc_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - mtpc_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MTPC_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= mtpc_pkg::QCNT_W'(mtpc_pkg::QUEUE_DEPTH))
   `MTPC_ASSERT_NEXT(a_pop_drains, clock, reset,
      do_pop && !do_push, count_ff == $past(count_ff) - mtpc_pkg::QCNT_W'(1))

endmodule

// ===== design/mtpc_back.sv =====
// ----------------------------------------------------------------------------
// Memory test pattern checker back end
// Compares read words with the expected pattern, counts bad bytes, drives results.
// ----------------------------------------------------------------------------
`include "memory_test_pattern_checker_assert.svh"

module mtpc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  mtpc_pkg::q_entry_type  q_entry,
   output logic                   q_pop,
   mtpc_rsp_if.source             rsp_port
);

   logic                             valid_ff;
   logic [mtpc_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic [mtpc_pkg::BYTES-1:0]       mask_ff, mask_in;
   logic [mtpc_pkg::PATTERN_W-1:0]   pattern_ff;
   logic [mtpc_pkg::BANK_W-1:0]      bank_ff;
   logic [mtpc_pkg::ROW_W-1:0]       row_ff;
   logic [mtpc_pkg::LINE_W-1:0]      line_ff;
   logic [mtpc_pkg::WORD_W-1:0]      word_ff;
   logic                             done_ff;

   logic [mtpc_pkg::DATA_W-1:0]      diff;
   logic [mtpc_pkg::CNT_W-1:0]       bad_count;
   logic [mtpc_pkg::TOTAL_W:0]       sum;

   assign q_pop = q_valid && (!valid_ff || rsp_port.ready);
   assign diff  = q_entry.read_word ^ {q_entry.pattern, q_entry.pattern};

   always_comb begin
      bad_count = '0;
      for (int i = 0; i < mtpc_pkg::BYTES; i++) begin
         mask_in[i] = q_entry.active && (diff[8*i +: 8] != 8'h00);
         bad_count  = bad_count + mtpc_pkg::CNT_W'(mask_in[i]);
      end
      sum = {1'b0, total_ff} + (mtpc_pkg::TOTAL_W + 1)'(bad_count);
      if (sum[mtpc_pkg::TOTAL_W]) begin
         total_in = mtpc_pkg::TOTAL_MAX;
      end else begin
         total_in = sum[mtpc_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         if (q_pop) begin
            valid_ff <= 1'b1;
            total_ff <= total_in;
         end else if (rsp_port.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         mask_ff    <= mask_in;
         pattern_ff <= q_entry.pattern;
         bank_ff    <= q_entry.bank;
         row_ff     <= q_entry.row;
         line_ff    <= q_entry.line;
         word_ff    <= q_entry.word;
         done_ff    <= q_entry.done;
      end
   end

   assign rsp_port.valid            = valid_ff;
   assign rsp_port.mismatch_mask    = mask_ff;
   assign rsp_port.expected_pattern = pattern_ff;
   assign rsp_port.bank_index       = bank_ff;
   assign rsp_port.row_index        = row_ff;
   assign rsp_port.line_index       = line_ff;
   assign rsp_port.word_index       = word_ff;
   assign rsp_port.error_total      = total_ff;
   assign rsp_port.run_done         = done_ff;

   `MTPC_ASSERT_NEXT(a_total_monotonic, clock, reset,
      1'b1, total_ff >= $past(total_ff))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory test pattern checker testbench
// Streams read words through the checker in four phases. The phases
// cover size clamping, the end of the run and the ignored words that follow
// it. Each word is predicted at acceptance and compared field by field with
// the in-order results.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [mtpc_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int IDLE_LIMIT = 1000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic [mtpc_pkg::PATTERN_W-1:0] pattern;
      logic [mtpc_pkg::WORD_W-1:0]    word;
      logic [mtpc_pkg::LINE_W-1:0]    line;
      logic [mtpc_pkg::ROW_W-1:0]     row;
      logic [mtpc_pkg::BANK_W-1:0]    bank;
      logic [mtpc_pkg::TOTAL_W-1:0]   total;
      logic                           finished;
      logic                           started;
   } pattern_walk_type;

   typedef struct {
      logic [mtpc_pkg::BYTES-1:0]     mask;
      logic [mtpc_pkg::PATTERN_W-1:0] pattern;
      logic [mtpc_pkg::BANK_W-1:0]    bank;
      logic [mtpc_pkg::ROW_W-1:0]     row;
      logic [mtpc_pkg::LINE_W-1:0]    line;
      logic [mtpc_pkg::WORD_W-1:0]    word;
      logic [mtpc_pkg::TOTAL_W-1:0]   total;
      logic                           done;
   } check_result_type;

   logic clock;
   logic reset;

   mtpc_req_if req_bus ();
   mtpc_rsp_if rsp_bus ();
   mtpc_csr_if csr_bus ();

   memory_test_pattern_checker dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   logic [mtpc_pkg::ROWS_W-1:0]    rows_cfg;
   logic [mtpc_pkg::BANKS_W-1:0]   banks_cfg;

   pattern_walk_type walk;
   pattern_walk_type plan_walk;

   logic [mtpc_pkg::DATA_W-1:0] pending_words[$];
   check_result_type            expected_checks[$];
   check_result_type            oldest;

   int mismatch_count;
   int burst_left;
   int gap_left;
   int idle_cycles;
   logic [15:0] stall_cycle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic check_result_type check_word(inout pattern_walk_type w,
                                                   input logic [mtpc_pkg::DATA_W-1:0] data);
      check_result_type                r;
      logic [mtpc_pkg::DATA_W-1:0]     diff;
      logic [mtpc_pkg::TOTAL_W:0]      sum;
      logic [mtpc_pkg::WORD_W:0]       next_word;
      logic [mtpc_pkg::LINE_W:0]       next_line;
      logic [mtpc_pkg::ROW_W:0]        next_row;
      logic [mtpc_pkg::BANK_W:0]       next_bank;
      int rows_eff;
      int banks_eff;
      int i;
      rows_eff  = (rows_cfg == 0) ? 1 :
                  (rows_cfg > mtpc_pkg::MAX_ROWS) ? mtpc_pkg::MAX_ROWS : int'(rows_cfg);
      banks_eff = (banks_cfg == 0) ? 1 :
                  (banks_cfg > mtpc_pkg::MAX_BANKS) ? mtpc_pkg::MAX_BANKS : int'(banks_cfg);
      r.mask    = '0;
      r.pattern = w.pattern;
      r.bank    = w.bank;
      r.row     = w.row;
      r.line    = w.line;
      r.word    = w.word;
      if (!w.finished) begin
         w.started = 1'b1;
         diff = data ^ {w.pattern, w.pattern};
         sum  = {1'b0, w.total};
         for (i = 0; i < mtpc_pkg::BYTES; i++) begin
            if (diff[8*i +: 8] != 8'd0) begin
               r.mask[i] = 1'b1;
               sum = sum + (mtpc_pkg::TOTAL_W + 1)'(1);
            end
         end
         w.total = (sum > mtpc_pkg::TOTAL_MAX) ? mtpc_pkg::TOTAL_MAX
                                                : sum[mtpc_pkg::TOTAL_W-1:0];
         next_word = {1'b0, w.word} + (mtpc_pkg::WORD_W + 1)'(1);
         if (next_word >= mtpc_pkg::WORDS_PER_LINE) begin
            w.word    = '0;
            w.pattern = {w.pattern[0], w.pattern[mtpc_pkg::PATTERN_W-1:1]};
            next_line = {1'b0, w.line} + (mtpc_pkg::LINE_W + 1)'(1);
            if (next_line >= mtpc_pkg::LINES_PER_ROW) begin
               w.line    = '0;
               w.pattern = w.pattern * mtpc_pkg::PATTERN_W'(3);
               next_row  = {1'b0, w.row} + (mtpc_pkg::ROW_W + 1)'(1);
               if (next_row >= rows_eff) begin
                  w.row     = '0;
                  next_bank = {1'b0, w.bank} + (mtpc_pkg::BANK_W + 1)'(1);
                  if (next_bank >= banks_eff) begin
                     w.bank     = '0;
                     w.finished = 1'b1;
                  end else begin
                     w.bank = next_bank[mtpc_pkg::BANK_W-1:0];
                  end
               end else begin
                  w.row = next_row[mtpc_pkg::ROW_W-1:0];
               end
            end else begin
               w.line = next_line[mtpc_pkg::LINE_W-1:0];
            end
         end else begin
            w.word = next_word[mtpc_pkg::WORD_W-1:0];
         end
      end
      r.total = w.total;
      r.done  = w.finished;
      return r;
   endfunction

   function automatic void clear_walk(inout pattern_walk_type w);
      w.pattern  = '0;
      w.word     = '0;
      w.line     = '0;
      w.row      = '0;
      w.bank     = '0;
      w.total    = '0;
      w.finished = 1'b0;
      w.started  = 1'b0;
   endfunction

   function automatic void plan_word(input logic [mtpc_pkg::DATA_W-1:0] data);
      void'(check_word(plan_walk, data));
      pending_words.push_back(data);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic csr_write(input logic [mtpc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mtpc_pkg::CSR_DATA_W-1:0] data, input bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (last) csr_bus.valid <= 1'b0;
      case (idx)
         mtpc_pkg::REG_SEED_PATTERN: begin
            if (!plan_walk.started) plan_walk.pattern = data;
         end
         mtpc_pkg::REG_ROWS_PER_BANK: rows_cfg = data[mtpc_pkg::ROWS_W-1:0];
         mtpc_pkg::REG_BANK_COUNT:    banks_cfg = data[mtpc_pkg::BANKS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_checks.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_directed();
      logic [mtpc_pkg::DATA_W-1:0] clean;
      int b;
      clean = {plan_walk.pattern, plan_walk.pattern};
      plan_word(clean);
      plan_word(~clean);
      plan_word('0);
      plan_word('1);
      for (b = 0; b < mtpc_pkg::BYTES; b++) begin
         clean = {plan_walk.pattern, plan_walk.pattern};
         plan_word(clean ^ (64'hFF << (8 * b)));
      end
      for (b = 0; b < mtpc_pkg::BYTES; b++) begin
         clean = {plan_walk.pattern, plan_walk.pattern};
         plan_word(clean ^ (64'h1 << (9 * b)));
      end
   endtask

   task automatic queue_random(input int count, input bit until_done);
      logic [mtpc_pkg::DATA_W-1:0] data;
      int n;
      int b;
      int pick;
      n = 0;
      while (n < count || (until_done && !plan_walk.finished)) begin
         data = {plan_walk.pattern, plan_walk.pattern};
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            data = {$urandom, $urandom};
         end else if (pick < 35) begin
            repeat ($urandom_range(1, 3)) begin
               b = $urandom_range(0, mtpc_pkg::BYTES - 1);
               data[8*b +: 8] = data[8*b +: 8] ^ 8'($urandom_range(1, 255));
            end
         end
         plan_word(data);
         n++;
      end
   endtask

   // sender: bursts of requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.read_word <= '0;
         burst_left = 1;
         gap_left   = 0;
         clear_walk(walk);
      end else begin
         if (csr_bus.valid && csr_bus.ready && csr_bus.index == mtpc_pkg::REG_SEED_PATTERN &&
             !walk.started)
            walk.pattern = csr_bus.data;
         if (req_bus.valid && req_bus.ready)
            expected_checks.push_back(check_word(walk, req_bus.read_word));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid     <= 1'b1;
               req_bus.read_word <= pending_words.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: stall pattern steps through four modes picked by stall_cycle[8:7]
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cycle = '0;
      end else begin
         stall_cycle++;
         case (stall_cycle[8:7])
            2'd0: rsp_bus.ready <= 1'b1;
            2'd1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_bus.ready <= (stall_cycle[2:0] != 3'd0);
            default: rsp_bus.ready <= !stall_cycle[3];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_checks.size() == 0) begin
            report_mismatch("result with no request", 64'(rsp_bus.mismatch_mask), '0);
         end else begin
            oldest = expected_checks.pop_front();
            if (rsp_bus.mismatch_mask !== oldest.mask)
               report_mismatch("mismatch_mask", 64'(rsp_bus.mismatch_mask),
                               64'(oldest.mask));
            if (rsp_bus.expected_pattern !== oldest.pattern)
               report_mismatch("expected_pattern", 64'(rsp_bus.expected_pattern),
                               64'(oldest.pattern));
            if (rsp_bus.bank_index !== oldest.bank)
               report_mismatch("bank_index", 64'(rsp_bus.bank_index), 64'(oldest.bank));
            if (rsp_bus.row_index !== oldest.row)
               report_mismatch("row_index", 64'(rsp_bus.row_index), 64'(oldest.row));
            if (rsp_bus.line_index !== oldest.line)
               report_mismatch("line_index", 64'(rsp_bus.line_index), 64'(oldest.line));
            if (rsp_bus.word_index !== oldest.word)
               report_mismatch("word_index", 64'(rsp_bus.word_index), 64'(oldest.word));
            if (rsp_bus.error_total !== oldest.total)
               report_mismatch("error_total", 64'(rsp_bus.error_total), 64'(oldest.total));
            if (rsp_bus.run_done !== oldest.done)
               report_mismatch("run_done", 64'(rsp_bus.run_done), 64'(oldest.done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR %0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = mtpc_pkg::REG_SEED_PATTERN;
      csr_bus.data  = '0;
      clear_walk(plan_walk);
      rows_cfg  = mtpc_pkg::ROWS_RESET;
      banks_cfg = mtpc_pkg::BANKS_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // seed loads the working pattern until the first word
      csr_write(mtpc_pkg::REG_SEED_PATTERN, '0, 0);
      csr_write(mtpc_pkg::REG_SEED_PATTERN, '1, 0);
      csr_write(CSR_UNMAPPED, $urandom, 0);
      csr_write(mtpc_pkg::REG_ROWS_PER_BANK, 32'h0000_8000, 0);
      csr_write(mtpc_pkg::REG_BANK_COUNT, 32'h0000_0010, 0);
      csr_write(mtpc_pkg::REG_SEED_PATTERN, $urandom, 1);
      queue_directed();
      queue_random(280, 0);
      wait_drained();

      // late seed write, oversized sizes clamp
      csr_write(mtpc_pkg::REG_SEED_PATTERN, $urandom, 0);
      csr_write(mtpc_pkg::REG_ROWS_PER_BANK, '1, 0);
      csr_write(mtpc_pkg::REG_BANK_COUNT, '1, 1);
      queue_random(500, 0);
      wait_drained();

      // zero rows and zero banks count as one: next row end finishes the run
      csr_write(mtpc_pkg::REG_ROWS_PER_BANK, 32'h0001_0000, 0);
      csr_write(mtpc_pkg::REG_BANK_COUNT, 32'hFFFF_FFE0, 1);
      queue_random(0, 1);
      wait_drained();

      csr_write(mtpc_pkg::REG_SEED_PATTERN, $urandom, 1);
      queue_random(520, 0);
      wait_drained();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
